/* rtl/core/i2cwm_pkg.sv */
// Shared types, codes and reset values of the I2C write master.
`default_nettype none

package i2cwm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_DEV_ADDR    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SS_TICKS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIT_TICKS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACK_TICKS   = 3'd4;

  localparam logic [6:0] DevAddrRst    = 7'h48;
  localparam logic [7:0] AckTimeoutRst = 8'd250;
  localparam logic [7:0] SsTicksRst    = 8'd4;
  localparam logic [7:0] BitTicksRst   = 8'd2;
  localparam logic [7:0] AckTicksRst   = 8'd1;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_ADDR = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_BIT_TRAIL,
    PH_ACK_SETUP,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_WAIT,
    PH_STOP_LO,
    PH_STOP_HI
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_count;
    logic [7:0] phase_ticks;
    logic [7:0] poll_count;
    logic [7:0] shift_byte;
    logic       pend_valid;
    logic       stop_after;
    logic       scl;
    logic       sda;
    logic       rel;
    logic       err;
  } st_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] ack_timeout;
    logic [7:0] ss_ticks;
    logic [7:0] bit_ticks;
    logic [7:0] ack_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic rel;
    logic busy;
    logic wants;
    logic accepted;
    logic done;
    logic nack;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/i2cwm_step.sv */
// Next-state and result logic for one item of the I2C write master.
`default_nettype none

module i2cwm_step (
  input  var i2cwm_pkg::st_t  st_i,
  input  var logic [7:0]      pend_byte_i,
  input  var i2cwm_pkg::cfg_t cfg_i,
  input  var logic [1:0]      func_i,
  input  var logic [7:0]      data_byte_i,
  input  var logic            last_byte_i,
  input  var logic            sda_in_i,
  output i2cwm_pkg::st_t      st_o,
  output logic [7:0]          pend_byte_o,
  output i2cwm_pkg::res_t     res_o
);

  logic [7:0] tick_inc;
  logic [7:0] len_sel;
  logic       over;
  logic [7:0] sh_next;
  logic [3:0] bc_next;
  logic       acc;
  logic       done;
  logic       nack;

  assign tick_inc = st_i.phase_ticks + 8'd1;
  assign sh_next  = {st_i.shift_byte[6:0], 1'b0};
  assign bc_next  = st_i.bit_count + 4'd1;

  always_comb begin
    case (st_i.phase) inside
      i2cwm_pkg::PH_START_HI, i2cwm_pkg::PH_START_LO,
      i2cwm_pkg::PH_STOP_LO, i2cwm_pkg::PH_STOP_HI: len_sel = cfg_i.ss_ticks;
      i2cwm_pkg::PH_ACK_SETUP, i2cwm_pkg::PH_ACK_HIGH: len_sel = cfg_i.ack_ticks;
      default: len_sel = cfg_i.bit_ticks;
    endcase
  end

  assign over = (tick_inc >= len_sel);

  always_comb begin
    st_o        = st_i;
    pend_byte_o = pend_byte_i;
    acc         = 1'b0;
    done        = 1'b0;
    nack        = 1'b0;
    if (func_i == i2cwm_pkg::FUNC_TICK) begin
      unique case (st_i.phase)
        i2cwm_pkg::PH_START_HI: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = 3'b100;
            st_o.phase       = i2cwm_pkg::PH_START_LO;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_START_LO: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            st_o.bit_count   = '0;
            {st_o.scl, st_o.sda, st_o.rel} = {1'b0, st_i.shift_byte[7], 1'b0};
            st_o.phase       = i2cwm_pkg::PH_BIT_LOW;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_BIT_LOW: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = {1'b1, st_i.shift_byte[7], 1'b0};
            st_o.phase       = i2cwm_pkg::PH_BIT_HIGH;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_BIT_HIGH: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = {1'b0, st_i.shift_byte[7], 1'b0};
            st_o.phase       = i2cwm_pkg::PH_BIT_TRAIL;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_BIT_TRAIL: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            st_o.shift_byte  = sh_next;
            st_o.bit_count   = bc_next;
            st_o.phase_ticks = '0;
            if (bc_next >= 4'd8) begin
              st_o.poll_count = '0;
              {st_o.scl, st_o.sda, st_o.rel} = 3'b011;
              st_o.phase = i2cwm_pkg::PH_ACK_SETUP;
            end else begin
              {st_o.scl, st_o.sda, st_o.rel} = {1'b0, sh_next[7], 1'b0};
              st_o.phase = i2cwm_pkg::PH_BIT_LOW;
            end
          end
        end
        i2cwm_pkg::PH_ACK_SETUP: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = 3'b111;
            st_o.phase       = i2cwm_pkg::PH_ACK_HIGH;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_ACK_HIGH: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            st_o.phase       = i2cwm_pkg::PH_ACK_POLL;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_ACK_POLL: begin
          if (!sda_in_i) begin
            st_o.phase_ticks = '0;
            if (st_i.pend_valid) begin
              st_o.shift_byte = pend_byte_i;
              st_o.pend_valid = 1'b0;
              st_o.bit_count  = '0;
              {st_o.scl, st_o.sda, st_o.rel} = {1'b0, pend_byte_i[7], 1'b0};
              st_o.phase      = i2cwm_pkg::PH_BIT_LOW;
            end else if (st_i.stop_after) begin
              {st_o.scl, st_o.sda, st_o.rel} = 3'b000;
              st_o.phase = i2cwm_pkg::PH_STOP_LO;
            end else begin
              {st_o.scl, st_o.sda, st_o.rel} = 3'b011;
              st_o.phase = i2cwm_pkg::PH_WAIT;
            end
          end else if (st_i.poll_count >= cfg_i.ack_timeout) begin
            st_o.err         = 1'b1;
            {st_o.scl, st_o.sda, st_o.rel} = 3'b000;
            st_o.phase       = i2cwm_pkg::PH_STOP_LO;
            st_o.phase_ticks = '0;
          end else begin
            st_o.poll_count = st_i.poll_count + 8'd1;
          end
        end
        i2cwm_pkg::PH_WAIT: begin
          if (st_i.pend_valid) begin
            st_o.shift_byte  = pend_byte_i;
            st_o.pend_valid  = 1'b0;
            st_o.bit_count   = '0;
            {st_o.scl, st_o.sda, st_o.rel} = {1'b0, pend_byte_i[7], 1'b0};
            st_o.phase       = i2cwm_pkg::PH_BIT_LOW;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_STOP_LO: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = 3'b100;
            st_o.phase       = i2cwm_pkg::PH_STOP_HI;
            st_o.phase_ticks = '0;
          end
        end
        i2cwm_pkg::PH_STOP_HI: begin
          st_o.phase_ticks = tick_inc;
          if (over) begin
            {st_o.scl, st_o.sda, st_o.rel} = 3'b110;
            st_o.phase       = i2cwm_pkg::PH_IDLE;
            st_o.phase_ticks = '0;
            done             = 1'b1;
            nack             = st_i.err;
            st_o.err         = 1'b0;
            st_o.stop_after  = 1'b0;
            st_o.pend_valid  = 1'b0;
          end
        end
        default: begin
          st_o.phase = i2cwm_pkg::PH_IDLE;
        end
      endcase
    end else if (func_i == i2cwm_pkg::FUNC_BYTE || func_i == i2cwm_pkg::FUNC_ADDR) begin
      if (st_i.phase == i2cwm_pkg::PH_IDLE) begin
        st_o.shift_byte = {cfg_i.dev_addr, 1'b0};
        if (func_i == i2cwm_pkg::FUNC_BYTE) begin
          pend_byte_o     = data_byte_i;
          st_o.pend_valid = 1'b1;
          st_o.stop_after = last_byte_i;
        end else begin
          st_o.pend_valid = 1'b0;
          st_o.stop_after = 1'b1;
        end
        st_o.err         = 1'b0;
        st_o.bit_count   = '0;
        st_o.poll_count  = '0;
        {st_o.scl, st_o.sda, st_o.rel} = 3'b110;
        st_o.phase       = i2cwm_pkg::PH_START_HI;
        st_o.phase_ticks = '0;
        acc              = 1'b1;
      end else if (func_i == i2cwm_pkg::FUNC_BYTE && !st_i.pend_valid && !st_i.stop_after &&
                   st_i.phase != i2cwm_pkg::PH_STOP_LO &&
                   st_i.phase != i2cwm_pkg::PH_STOP_HI) begin
        pend_byte_o     = data_byte_i;
        st_o.pend_valid = 1'b1;
        st_o.stop_after = last_byte_i;
        acc             = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.scl      = st_o.scl;
    res_o.sda      = st_o.sda;
    res_o.rel      = st_o.rel;
    res_o.busy     = (st_o.phase != i2cwm_pkg::PH_IDLE);
    res_o.wants    = (st_o.phase == i2cwm_pkg::PH_WAIT);
    res_o.accepted = acc;
    res_o.done     = done;
    res_o.nack     = nack;
  end

endmodule

`default_nettype wire

/* rtl/core/i2c_write_master.sv */
// Top level of the write-only I2C master with line levels as results.
//
// Input channel (in_valid_i/in_ready_o): each item is a bus tick (func 0,
// carrying the sampled SDA level), a data byte submission (func 1) or an
// address-only transfer request (func 2). Every item yields exactly one result
// item on the output channel (out_valid_o/out_ready_i) with the SCL/SDA levels,
// the SDA release flag, busy and wants-byte status, and the accepted, done and
// NACK flags.
// The state update runs between the input port and the result register in a
// single pass. Throughput: one item per cycle unless out_ready_i stalls it.
// Stall: while a result sits in the result register and out_ready_i is low,
// in_ready_o is low; the block resumes as soon as the result is taken.
// Reset: the bus idles with SCL high and SDA driven high, no transfer, and the
// configuration registers return to address 0x48, timeout 250, start/stop 4,
// bit phase 2 and acknowledge setup/high 1 ticks.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// write only while no item is in flight.
`default_nettype none

module i2c_write_master (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic                              cfg_we_i,
  input  var logic [i2cwm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  var logic [i2cwm_pkg::CfgDataW-1:0]    cfg_data_i,
  input  var logic                              in_valid_i,
  output logic                                  in_ready_o,
  input  var logic [1:0]                        func_i,
  input  var logic [7:0]                        data_byte_i,
  input  var logic                              last_byte_i,
  input  var logic                              sda_in_i,
  output logic                                  out_valid_o,
  input  var logic                              out_ready_i,
  output logic                                  scl_level_o,
  output logic                                  sda_level_o,
  output logic                                  sda_released_o,
  output logic                                  busy_res_o,
  output logic                                  wants_byte_o,
  output logic                                  accepted_o,
  output logic                                  transfer_done_o,
  output logic                                  nack_error_o
);

  i2cwm_pkg::cfg_t cfg_q;
  i2cwm_pkg::st_t  st_q, st_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  i2cwm_pkg::res_t res_q, res_d;
  logic            out_valid_q;
  logic            in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= i2cwm_pkg::DevAddrRst;
      cfg_q.ack_timeout <= i2cwm_pkg::AckTimeoutRst;
      cfg_q.ss_ticks    <= i2cwm_pkg::SsTicksRst;
      cfg_q.bit_ticks   <= i2cwm_pkg::BitTicksRst;
      cfg_q.ack_ticks   <= i2cwm_pkg::AckTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cwm_pkg::REG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data_i[6:0];
        i2cwm_pkg::REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        i2cwm_pkg::REG_SS_TICKS:    cfg_q.ss_ticks    <= cfg_data_i;
        i2cwm_pkg::REG_BIT_TICKS:   cfg_q.bit_ticks   <= cfg_data_i;
        i2cwm_pkg::REG_ACK_TICKS:   cfg_q.ack_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cwm_step u_step (
    .st_i        (st_q),
    .pend_byte_i (pend_byte_q),
    .cfg_i       (cfg_q),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .sda_in_i    (sda_in_i),
    .st_o        (st_d),
    .pend_byte_o (pend_byte_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= i2cwm_pkg::PH_IDLE;
      st_q.bit_count   <= '0;
      st_q.phase_ticks <= '0;
      st_q.poll_count  <= '0;
      st_q.shift_byte  <= '0;
      st_q.pend_valid  <= 1'b0;
      st_q.stop_after  <= 1'b0;
      st_q.scl         <= 1'b1;
      st_q.sda         <= 1'b1;
      st_q.rel         <= 1'b0;
      st_q.err         <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_byte_q <= pend_byte_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_level_o     = res_q.scl;
  assign sda_level_o     = res_q.sda;
  assign sda_released_o  = res_q.rel;
  assign busy_res_o      = res_q.busy;
  assign wants_byte_o    = res_q.wants;
  assign accepted_o      = res_q.accepted;
  assign transfer_done_o = res_q.done;
  assign nack_error_o    = res_q.nack;

endmodule

`default_nettype wire

/* rtl/core/i2cwm_checker.sv */
// Port-level checks of the I2C write master and their binding.
`default_nettype none

module i2cwm_checker (
  input var logic clk_i,
  input var logic rst_ni,
  input var logic in_valid_i,
  input var logic in_ready_o,
  input var logic out_valid_o,
  input var logic out_ready_i,
  input var logic scl_level_o,
  input var logic sda_level_o,
  input var logic sda_released_o,
  input var logic busy_res_o,
  input var logic wants_byte_o,
  input var logic transfer_done_o,
  input var logic nack_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(transfer_done_o) &&
    $stable(scl_level_o) && $stable(busy_res_o))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_done_o |-> !busy_res_o && scl_level_o && sda_level_o)
    else $error("done without bus released to idle");

  a_nack_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nack_error_o |-> transfer_done_o)
    else $error("nack without done");

  a_wait_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wants_byte_o |-> busy_res_o && !scl_level_o && sda_released_o)
    else $error("waiting for byte with wrong line levels");

endmodule

bind i2c_write_master i2cwm_checker u_i2cwm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .scl_level_o     (scl_level_o),
  .sda_level_o     (sda_level_o),
  .sda_released_o  (sda_released_o),
  .busy_res_o      (busy_res_o),
  .wants_byte_o    (wants_byte_o),
  .transfer_done_o (transfer_done_o),
  .nack_error_o    (nack_error_o)
);

`default_nettype wire
